### design/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list table engine
// Command codes, field widths and the default list depth.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned IN_W      = 64;
  localparam int unsigned OUT_W     = 48;

  typedef enum logic [3:0] {
    CMD_APPEND = 4'd0,
    CMD_INSERT = 4'd1,
    CMD_REMOVE = 4'd2,
    CMD_READ   = 4'd3,
    CMD_WRITE  = 4'd4,
    CMD_FIND   = 4'd5,
    CMD_FINDT  = 4'd6,
    CMD_ROTR   = 4'd7,
    CMD_ROTL   = 4'd8
  } cmd_t;

endpackage

### design/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ile_mod.sv
// ----------------------------------------------------------------------------
// ile_mod: iterative remainder unit
// Restoring division, one numerator bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ile_mod #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int unsigned SW = (NW > 1) ? $clog2(NW) : 1;

  logic          run_r;
  logic          done_r;
  logic [SW-1:0] stp_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   sh;
  logic [DW-1:0] rem_nxt;

  assign sh = {rem_r, num_r[NW-1]};

  always_comb begin
    if (sh >= {1'b0, den}) begin
      rem_nxt = DW'(sh - {1'b0, den});
    end else begin
      rem_nxt = DW'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      stp_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        stp_r <= '0;
        num_r <= num;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        stp_r <= stp_r + SW'(1);
        if (stp_r == SW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### design/indexed_list_table_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_table_engine: bounded list of signed words in one RAM
// Insert, remove and rotate-left move entries one at a time; find scans from the
// front and a transposing find swaps the hit forward. Rotate-right first reduces
// the amount in the remainder unit, then copies the list through scratch RAM.
// One request at a time. Reset clears the entry count and handshake state;
// list RAM is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_table_engine #(
  parameter int unsigned DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata, from bit 0: cmd[3:0], value[35:4], position[41:36],
  // shift_amount[57:42], zero fill [63:58]
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [ile_pkg::IN_W-1:0] in_tdata,
  // out_tdata, from bit 0: read_value[31:0], result_index[37:32], found[38],
  // error[39], entry_count[46:40], zero fill [47]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ile_pkg::OUT_W-1:0] out_tdata
);

  import ile_pkg::*;

  // Address width of the list RAM and width of the entry count.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Width in which a requested position is compared with the count.
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  // The controller walks the list one RAM access per cycle. Each read issued
  // in one cycle returns its data in the next, where it is used or written back.
  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_PUT, S_INS, S_REMRD, S_SHIFT, S_RDW,
    S_FIND, S_MOD, S_ROTA, S_ROTW, S_ROTB, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [WORD_W-1:0]   val_r, val_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [AMT_W-1:0]    amt_r, amt_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       tgt_r, tgt_nxt;
  logic [WORD_W-1:0]   prev_r, prev_nxt;
  logic [WORD_W-1:0]   rd_r, rd_nxt;
  logic [POS_W-1:0]    ridx_r, ridx_nxt;
  logic                fnd_r, fnd_nxt;
  logic                err_r, err_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;

  // List RAM and scratch RAM ports.
  logic                l_we, s_we;
  logic [AW-1:0]       l_waddr, l_raddr, s_waddr, s_raddr;
  logic [WORD_W-1:0]   l_wdata, l_rdata, s_wdata, s_rdata;

  logic                mod_start, mod_done;
  logic [CW-1:0]       mod_rem;

  logic [XW-1:0]       pos_x, cnt_x;
  logic                full;

  assign pos_x = XW'(pos_r);
  assign cnt_x = XW'(cnt_r);
  assign full  = (cnt_r == CW'(DEPTH));

  ile_ram #(.W(WORD_W), .D(DEPTH)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // Scratch copy used only by rotate-right.
  ile_ram #(.W(WORD_W), .D(DEPTH)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // Reduces the rotate amount modulo the entry count.
  ile_mod #(.NW(AMT_W), .DW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .num(amt_r),
    .den(cnt_r), .done(mod_done), .rem(mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    amt_nxt        = amt_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    tgt_nxt        = tgt_r;
    prev_nxt       = prev_r;
    rd_nxt         = rd_r;
    ridx_nxt       = ridx_r;
    fnd_nxt        = fnd_r;
    err_nxt        = err_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    l_we           = 1'b0;
    l_waddr        = tgt_r;
    l_wdata        = val_r;
    l_raddr        = '0;
    s_we           = 1'b0;
    s_waddr        = j_r;
    s_wdata        = l_rdata;
    s_raddr        = '0;
    mod_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tdata[3:0]);
          val_nxt   = in_tdata[35:4];
          pos_nxt   = in_tdata[41:36];
          amt_nxt   = in_tdata[57:42];
          rd_nxt    = '0;
          ridx_nxt  = '0;
          fnd_nxt   = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_APPEND: begin
            if (full) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              tgt_nxt   = AW'(cnt_r);
              state_nxt = S_PUT;
            end
          end
          CMD_INSERT: begin
            tgt_nxt = AW'(pos_r);
            if (full || pos_x > cnt_x) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else if (pos_x == cnt_x) begin
              state_nxt = S_PUT;
            end else begin
              // Shift from the top down: read entry count-1 first.
              l_raddr   = AW'(cnt_r - CW'(1));
              i_nxt     = cnt_r;
              state_nxt = S_INS;
            end
          end
          CMD_REMOVE: begin
            if (pos_x >= cnt_x) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              l_raddr   = AW'(pos_r);
              i_nxt     = CW'(pos_r);
              state_nxt = S_REMRD;
            end
          end
          CMD_ROTL: begin
            if (cnt_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              // The head goes to the last slot once the rest has moved down.
              l_raddr   = '0;
              i_nxt     = '0;
              tgt_nxt   = AW'(cnt_r - CW'(1));
              state_nxt = S_REMRD;
            end
          end
          CMD_READ: begin
            if (pos_x >= cnt_x) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              l_raddr   = AW'(pos_r);
              state_nxt = S_RDW;
            end
          end
          CMD_WRITE: begin
            if (pos_x >= cnt_x) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              tgt_nxt   = AW'(pos_r);
              state_nxt = S_PUT;
            end
          end
          CMD_FIND, CMD_FINDT: begin
            if (cnt_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              l_raddr   = '0;
              i_nxt     = '0;
              state_nxt = S_FIND;
            end
          end
          CMD_ROTR: begin
            if (cnt_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_PUT: begin
        l_we = 1'b1;
        if (cmd_r == CMD_APPEND || cmd_r == CMD_INSERT) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_FIN;
      end
      S_INS: begin
        // Data of entry i-1 is back; it moves up to entry i.
        l_we    = 1'b1;
        l_waddr = AW'(i_r);
        l_wdata = l_rdata;
        i_nxt   = i_r - CW'(1);
        if (i_r - CW'(1) == CW'(pos_r)) begin
          state_nxt = S_PUT;
        end else begin
          l_raddr = AW'(i_r - CW'(2));
        end
      end
      S_REMRD: begin
        if (cmd_r == CMD_REMOVE) begin
          rd_nxt = l_rdata;
        end else begin
          val_nxt = l_rdata;
        end
        if (i_r + CW'(1) == cnt_r) begin
          if (cmd_r == CMD_REMOVE) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          l_raddr   = AW'(i_r + CW'(1));
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Data of entry i+1 is back; it moves down to entry i.
        l_we    = 1'b1;
        l_waddr = AW'(i_r);
        l_wdata = l_rdata;
        i_nxt   = i_r + CW'(1);
        if (i_r + CW'(2) < cnt_r) begin
          l_raddr = AW'(i_r + CW'(2));
        end else if (cmd_r == CMD_REMOVE) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_RDW: begin
        rd_nxt    = l_rdata;
        state_nxt = S_FIN;
      end
      S_FIND: begin
        if (l_rdata == val_r) begin
          fnd_nxt = 1'b1;
          if (cmd_r == CMD_FIND || i_r == '0) begin
            ridx_nxt  = POS_W'(i_r);
            state_nxt = S_FIN;
          end else begin
            // Swap with the previous entry: the previous word goes here now,
            // the matched word (equal to the key) goes one place up front.
            ridx_nxt  = POS_W'(i_r - CW'(1));
            l_we      = 1'b1;
            l_waddr   = AW'(i_r);
            l_wdata   = prev_r;
            tgt_nxt   = AW'(i_r - CW'(1));
            state_nxt = S_PUT;
          end
        end else begin
          prev_nxt = l_rdata;
          if (i_r + CW'(1) == cnt_r) begin
            state_nxt = S_FIN;
          end else begin
            l_raddr = AW'(i_r + CW'(1));
            i_nxt   = i_r + CW'(1);
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            state_nxt = S_FIN;
          end else begin
            l_raddr   = '0;
            i_nxt     = '0;
            j_nxt     = AW'(mod_rem);
            state_nxt = S_ROTA;
          end
        end
      end
      S_ROTA: begin
        // Entry i lands in scratch slot (i + k) mod count.
        s_we = 1'b1;
        if (CW'(j_r) + CW'(1) == cnt_r) begin
          j_nxt = '0;
        end else begin
          j_nxt = j_r + AW'(1);
        end
        if (i_r + CW'(1) < cnt_r) begin
          l_raddr = AW'(i_r + CW'(1));
          i_nxt   = i_r + CW'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = S_ROTW;
        end
      end
      S_ROTW: begin
        // The last scratch write may hit slot 0, so slot 0 is read only after that write.
        s_raddr   = '0;
        state_nxt = S_ROTB;
      end
      S_ROTB: begin
        // Copy the scratch image back into the list.
        l_we    = 1'b1;
        l_waddr = AW'(i_r);
        l_wdata = s_rdata;
        if (i_r + CW'(1) < cnt_r) begin
          s_raddr = AW'(i_r + CW'(1));
          i_nxt   = i_r + CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, CNT_OUT_W'(cnt_r), err_r, fnd_r, ridx_r, rd_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    pos_r       <= pos_nxt;
    amt_r       <= amt_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    tgt_r       <= tgt_nxt;
    prev_r      <= prev_nxt;
    rd_r        <= rd_nxt;
    ridx_r      <= ridx_nxt;
    fnd_r       <= fnd_nxt;
    err_r       <= err_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // A request is taken only between commands; the result register is separate.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> out_tdata[38:0] == '0)
    else $error("error result carries data");

  a_rotate_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> mod_rem < cnt_r)
    else $error("rotate amount not reduced below count");
`endif

endmodule

### tb/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker: request/response scoreboard for the indexed list engine
// Mirrors the list in a local array, predicts one response per accepted
// request and compares it field by field with the engine's output.
// ----------------------------------------------------------------------------
module list_checker
  import ile_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [6:0]        entry_count;
    logic              error;
    logic              found;
    logic [POS_W-1:0]  result_index;
    logic [WORD_W-1:0] read_value;
  } resp_t;

  logic [WORD_W-1:0] mirror [DEPTH];
  int unsigned       mirror_count;
  resp_t             resp_queue [$];

  assign pending = resp_queue.size();

  function automatic resp_t apply_request(logic [IN_W-1:0] req);
    cmd_t              cmd;
    logic [WORD_W-1:0] word, held;
    int unsigned       pos, amt, hit;
    logic [WORD_W-1:0] tmp [DEPTH];
    resp_t             r;
    cmd  = cmd_t'(req[3:0]);
    word = req[35:4];
    pos  = 32'(req[41:36]);
    amt  = 32'(req[57:42]);
    r    = '0;
    hit  = DEPTH;
    case (cmd)
      CMD_APPEND: begin
        if (mirror_count >= DEPTH) r.error = 1'b1;
        else begin
          mirror[mirror_count] = word;
          mirror_count++;
        end
      end
      CMD_INSERT: begin
        if (mirror_count >= DEPTH || pos > mirror_count) r.error = 1'b1;
        else begin
          for (int i = mirror_count; i > pos; i--) mirror[i] = mirror[i-1];
          mirror[pos] = word;
          mirror_count++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= mirror_count) r.error = 1'b1;
        else begin
          r.read_value = mirror[pos];
          for (int i = pos; i + 1 < mirror_count; i++) mirror[i] = mirror[i+1];
          mirror_count--;
        end
      end
      CMD_READ: begin
        if (pos >= mirror_count) r.error = 1'b1;
        else r.read_value = mirror[pos];
      end
      CMD_WRITE: begin
        if (pos >= mirror_count) r.error = 1'b1;
        else mirror[pos] = word;
      end
      CMD_FIND, CMD_FINDT: begin
        for (int i = 0; i < mirror_count; i++)
          if (hit == DEPTH && mirror[i] == word) hit = i;
        if (hit < DEPTH) begin
          r.found = 1'b1;
          // The transposition moves a hit one slot toward the front.
          if (cmd == CMD_FINDT && hit > 0) begin
            held          = mirror[hit];
            mirror[hit]   = mirror[hit-1];
            mirror[hit-1] = held;
            hit--;
          end
          r.result_index = POS_W'(hit);
        end
      end
      CMD_ROTR: begin
        if (mirror_count != 0) begin
          amt = amt % mirror_count;
          for (int i = 0; i < mirror_count; i++)
            tmp[(i + amt) % mirror_count] = mirror[i];
          for (int i = 0; i < mirror_count; i++) mirror[i] = tmp[i];
        end
      end
      CMD_ROTL: begin
        if (mirror_count != 0) begin
          held = mirror[0];
          for (int i = 0; i + 1 < mirror_count; i++) mirror[i] = mirror[i+1];
          mirror[mirror_count-1] = held;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(mirror_count);
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want, got;
    if (!rst_n) begin
      mirror_count = 0;
      fail_count   <= 0;
      resp_queue.delete();
    end else begin
      if (in_tvalid && in_tready) resp_queue = {resp_queue, apply_request(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = resp_t'(out_tdata[46:0]);
        if (resp_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected response %h", out_tdata);
        end else begin
          want = resp_queue.pop_front();
          if (got !== want || out_tdata[47] !== 1'b0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: expected val=%h idx=%0d fnd=%b err=%b cnt=%0d,",
                        " got val=%h idx=%0d fnd=%b err=%b cnt=%0d"},
                       want.read_value, want.result_index, want.found, want.error,
                       want.entry_count, got.read_value, got.result_index, got.found,
                       got.error, got.entry_count);
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the indexed list engine
// Drives directed then random command streams with random gaps on both
// channels; a side checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
  import ile_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  int               fail_count, pending;
  int               cycle_count = 0;
  // The model count follows the list size only roughly, to steer positions.
  int               size_guess = 0;

  always #5 clk = ~clk;

  indexed_list_table_engine uut (.*);
  list_checker chk (.*);

  // Timeout: the limit is far above the longest request plus its gaps.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls a random number of cycles before each response.
  initial begin
    int gap;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // A pool of recent words makes finds hit more often than pure random.
  logic [31:0] word_pool [16];

  task automatic send_request(cmd_t cmd, logic [31:0] word, int pos, int amt);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'd0, amt[15:0], pos[5:0], word, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    case (cmd)
      CMD_APPEND: if (size_guess < 64) size_guess++;
      CMD_INSERT: if (size_guess < 64 && pos <= size_guess) size_guess++;
      CMD_REMOVE: if (pos < size_guess) size_guess--;
      default: ;
    endcase
  endtask

  task automatic send_random();
    int   sel, pos, amt;
    cmd_t cmd;
    logic [31:0] word;
    sel  = $urandom_range(0, 99);
    word = ($urandom_range(0, 1) == 0) ? word_pool[$urandom_range(0, 15)] : $urandom();
    if (sel < 4) word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    word_pool[$urandom_range(0, 15)] = word;
    // Positions are mostly in range, with some just past and a few wild.
    case ($urandom_range(0, 9))
      0:       pos = $urandom_range(0, 63);
      1:       pos = (size_guess > 63) ? 63 : size_guess;
      default: pos = (size_guess == 0) ? 0 : $urandom_range(0, size_guess - 1);
    endcase
    amt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 130);
    // Grow the list when it is small, drain it when it is close to full.
    if (size_guess < 8)
      cmd = ($urandom_range(0, 2) != 0) ? CMD_APPEND : cmd_t'($urandom_range(0, 8));
    else if (size_guess > 60)
      cmd = ($urandom_range(0, 2) == 0) ? CMD_REMOVE : cmd_t'($urandom_range(0, 8));
    else
      cmd = cmd_t'($urandom_range(0, 8));
    if ($urandom_range(0, 49) == 0) cmd = cmd_t'($urandom_range(9, 15));
    send_request(cmd, word, pos, amt);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) word_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors and rotations, then edges of the list.
    send_request(CMD_ROTR, 32'd0, 0, 5);
    send_request(CMD_ROTL, 32'd0, 0, 0);
    send_request(CMD_READ, 32'd0, 0, 0);
    send_request(CMD_REMOVE, 32'd0, 0, 0);
    send_request(CMD_WRITE, 32'd1, 0, 0);
    send_request(CMD_INSERT, 32'h8000_0000, 1, 0);
    send_request(CMD_INSERT, 32'h8000_0000, 0, 0);
    send_request(CMD_APPEND, 32'h7fff_ffff, 0, 0);
    send_request(CMD_APPEND, 32'hffff_ffff, 0, 0);
    send_request(CMD_INSERT, 32'd0, 3, 0);
    send_request(CMD_FINDT, 32'h8000_0000, 0, 0);
    send_request(CMD_FINDT, 32'd0, 0, 0);
    send_request(CMD_FIND, 32'h1234_5678, 0, 0);
    send_request(CMD_FIND, 32'hffff_ffff, 0, 0);
    send_request(CMD_ROTR, 32'd0, 0, 16'hffff);
    send_request(CMD_ROTR, 32'd0, 0, 4);
    send_request(CMD_ROTL, 32'd0, 0, 0);
    send_request(CMD_WRITE, 32'h5555_aaaa, 63, 0);
    send_request(cmd_t'(4'd15), 32'hffff_ffff, 63, 16'hffff);
    send_request(cmd_t'(4'd9), 32'd0, 0, 0);
    send_request(CMD_REMOVE, 32'd0, 3, 0);
    send_request(CMD_READ, 32'd0, 1, 0);
    // Fill to capacity and hit the full-list errors.
    while (size_guess < 64) send_request(CMD_APPEND, $urandom(), 0, 0);
    send_request(CMD_APPEND, 32'd1, 0, 0);
    send_request(CMD_INSERT, 32'd1, 0, 0);
    send_request(CMD_READ, 32'd0, 63, 0);

    repeat (1460) send_random();
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
design/ile_pkg.sv
design/ile_ram.sv
design/ile_mod.sv
design/indexed_list_table_engine.sv
tb/list_checker.sv
tb/testbench.sv
